[src/amma_pkg.sv]
// ----------------------------------------------------------------------------
// amma_pkg: shared types and constants
// Holds the sequencer state type and the fixed field widths of the
// accelerometer magnitude moving-average block.
// ----------------------------------------------------------------------------
package amma_pkg;

  // Fixed widths of the result fields
  localparam int MAG_W     = 24;
  localparam int CNT_OUT_W = 6;
  localparam int OUT_W     = ((MAG_W + CNT_OUT_W + 7) / 8) * 8;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } amma_state_t;

endpackage

[src/accel_magnitude_moving_average.sv]
// ----------------------------------------------------------------------------
// accel_magnitude_moving_average: mean magnitude over a sliding window
// Computes sqrt(x^2+y^2+z^2) of each sample in fixed point and reports the
// mean of the nonzero magnitudes among the last WINDOW_DEPTH samples.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (tdata = x, y, z, lowest bits first) and
//   results leave on the m_ channel (tdata = mean magnitude, nonzero count).
//   Each request yields exactly one result.
//   One request is worked on at a time; s_tready is high only while the
//   sequencer is idle. A request passes through the SQUARE, ROOT, UPDATE,
//   DIVIDE and DONE states, with R = SAMPLE_WIDTH + 1 + FRACTION_BITS
//   square-root steps and S = 24 + clog2(WINDOW_DEPTH) divide steps, both run
//   on one shared subtract/compare unit; the squares share one multiplier.
//   The result sits in an output register, so a stalled receiver does not
//   stop the next request from being accepted and computed; the sequencer
//   waits in its last step only if the old result is still not taken.
//   Reset does not clear the window memory; entries are treated as zero
//   until the write pointer first wraps. Reset clears the sum, count and pointer.
// ----------------------------------------------------------------------------
module accel_magnitude_moving_average
  import amma_pkg::*;
#(
  parameter int WINDOW_DEPTH  = 32,
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // accel_x, accel_y, accel_z (signed), zero padded to whole bytes
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // mean_magnitude [23:0], nonzero_count [29:24], zero padded
  output logic [OUT_W-1:0] m_tdata
);

  localparam int SW       = SAMPLE_WIDTH;
  localparam int SQ_W     = 2 * SW + 2;
  localparam int N_W      = SQ_W + 2 * FRACTION_BITS;
  localparam int R_W      = N_W / 2;
  localparam int PTR_W    = $clog2(WINDOW_DEPTH);
  localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W    = MAG_W + $clog2(WINDOW_DEPTH);
  localparam int SUB_W    = (R_W + 2 > CNT_W + 1) ? R_W + 2 : CNT_W + 1;
  localparam int ITER_MAX = (R_W > SUM_W) ? R_W : SUM_W;
  localparam int ITER_W   = $clog2(ITER_MAX);
  localparam int PAD_W    = OUT_W - MAG_W - CNT_OUT_W;

  amma_state_t state, state_next;

  logic [SW-1:0]     abs_x, abs_y, abs_z;
  logic [SW-1:0]     in_x, in_y, in_z;
  logic [ITER_W-1:0] iter;
  logic [SQ_W-1:0]   acc;
  logic [N_W-1:0]    rad;
  logic [R_W-1:0]    root;
  logic [SUB_W-1:0]  rem;
  logic [SUM_W-1:0]  dvd;
  logic [SUM_W-1:0]  window_sum;
  logic [CNT_W-1:0]  live_count;
  logic [PTR_W-1:0]  write_pointer;
  logic              wrapped;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  mem_rd;
  logic [MAG_W-1:0]  magnitude_window [WINDOW_DEPTH];

  logic              in_accept;
  logic              out_load;
  logic [SW-1:0]     mul_op;
  logic [2*SW-1:0]   mul_prod;
  logic [SQ_W-1:0]   acc_next;
  logic [SUB_W-1:0]  sub_a, sub_b;
  logic [SUB_W:0]    sub_diff;
  logic              sub_ge;
  logic [MAG_W-1:0]  old_mag;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count_next;
  logic [MAG_W-1:0]  out_mean;
  logic [CNT_OUT_W-1:0] out_count;

  assign in_x = s_tdata[SW-1:0];
  assign in_y = s_tdata[2*SW-1:SW];
  assign in_z = s_tdata[3*SW-1:2*SW];

  // Handshakes
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Shared multiplier: square one axis per cycle
  always_comb begin
    case (iter)
      ITER_W'(2): mul_op = abs_x;
      ITER_W'(1): mul_op = abs_y;
      default:    mul_op = abs_z;
    endcase
  end
  assign mul_prod = mul_op * mul_op;
  assign acc_next = acc + SQ_W'(mul_prod);

  // Shared subtract/compare unit for root and divide steps
  always_comb begin
    if (state == ST_ROOT) begin
      sub_a = {rem[SUB_W-3:0], rad[N_W-1 -: 2]};
      sub_b = SUB_W'({root, 2'b01});
    end else begin
      sub_a = {rem[SUB_W-2:0], dvd[SUM_W-1]};
      sub_b = SUB_W'(live_count);
    end
  end
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[SUB_W];

  // Window bookkeeping: entries read as zero until the first wrap
  assign mag        = MAG_W'(root);
  assign old_mag    = wrapped ? mem_rd : '0;
  assign sum_next   = window_sum - SUM_W'(old_mag) + SUM_W'(mag);
  assign count_next = live_count - CNT_W'(old_mag != '0) + CNT_W'(mag != '0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_accept) state_next = ST_SQUARE;
      ST_SQUARE: if (iter == '0) state_next = ST_ROOT;
      ST_ROOT:   if (iter == '0) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DIVIDE;
      ST_DIVIDE: if (iter == '0) state_next = ST_DONE;
      ST_DONE:   if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window store: read the oldest slot at accept, overwrite it at update
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem_rd <= magnitude_window[write_pointer];
    end
    if (state == ST_UPDATE) begin
      magnitude_window[write_pointer] <= mag;
    end
  end

  // Running sum, count and pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum    <= '0;
      live_count    <= '0;
      write_pointer <= '0;
      wrapped       <= 1'b0;
    end else if (state == ST_UPDATE) begin
      window_sum <= sum_next;
      live_count <= count_next;
      if (write_pointer == PTR_W'(WINDOW_DEPTH - 1)) begin
        write_pointer <= '0;
        wrapped       <= 1'b1;
      end else begin
        write_pointer <= write_pointer + PTR_W'(1);
      end
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        abs_x <= in_x[SW-1] ? (~in_x + SW'(1)) : in_x;
        abs_y <= in_y[SW-1] ? (~in_y + SW'(1)) : in_y;
        abs_z <= in_z[SW-1] ? (~in_z + SW'(1)) : in_z;
        acc   <= '0;
        iter  <= ITER_W'(2);
      end
      ST_SQUARE: begin
        acc <= acc_next;
        if (iter == '0) begin
          rad  <= N_W'(acc_next) << (2 * FRACTION_BITS);
          root <= '0;
          rem  <= '0;
          iter <= ITER_W'(R_W - 1);
        end else begin
          iter <= iter - ITER_W'(1);
        end
      end
      ST_ROOT: begin
        rad <= rad << 2;
        if (sub_ge) begin
          rem  <= sub_diff[SUB_W-1:0];
          root <= {root[R_W-2:0], 1'b1};
        end else begin
          rem  <= sub_a;
          root <= {root[R_W-2:0], 1'b0};
        end
        iter <= iter - ITER_W'(1);
      end
      ST_UPDATE: begin
        dvd  <= sum_next;
        rem  <= '0;
        iter <= ITER_W'(SUM_W - 1);
      end
      ST_DIVIDE: begin
        if (sub_ge) begin
          rem <= sub_diff[SUB_W-1:0];
        end else begin
          rem <= sub_a;
        end
        dvd  <= {dvd[SUM_W-2:0], sub_ge};
        iter <= iter - ITER_W'(1);
      end
      default: begin
        iter <= iter;
      end
    endcase
  end

  // Output register: hold until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean  <= (live_count == '0) ? '0 : MAG_W'(dvd);
      out_count <= CNT_OUT_W'(live_count);
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_count, out_mean};

endmodule

[src/amma_checker.sv]
// ----------------------------------------------------------------------------
// amma_checker: port-level checks
// Watches the request and result channels of the magnitude moving-average
// block and flags protocol or result slips.
// ----------------------------------------------------------------------------
module amma_checker
  import amma_pkg::*;
#(
  parameter int WINDOW_DEPTH = 32
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // Drop ready after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  // Count never exceeds the window depth (checked for depths below 64)
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (WINDOW_DEPTH >= 64) ||
                 (m_tdata[MAG_W +: CNT_OUT_W] <= CNT_OUT_W'(WINDOW_DEPTH)))
    else $error("nonzero count above window depth");

  // Empty window gives a zero mean
  a_empty_mean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[MAG_W +: CNT_OUT_W] == '0) && (WINDOW_DEPTH < 64)
      |-> (m_tdata[MAG_W-1:0] == '0))
    else $error("nonzero mean with empty window");

endmodule

bind accel_magnitude_moving_average amma_checker #(
  .WINDOW_DEPTH(WINDOW_DEPTH)
) u_amma_checker (.*);
